FILE: rtl/core/mm_pkg.sv
// Shared types, constants and helpers for the matrix multiply block.
// No dependencies; every other file but mm_ram refers to it by scoped names.
package mm_pkg;

	localparam int MAX_DIM    = 8;
	localparam int DATA_WIDTH = 16;
	localparam int DIM_W      = $clog2(MAX_DIM);
	localparam int CNT_W      = $clog2(MAX_DIM + 1);
	localparam int ADDR_W     = 2 * DIM_W;
	localparam int DEPTH      = MAX_DIM * MAX_DIM;
	localparam int CFG_W      = 4;
	localparam int ACC_W      = 48;
	localparam int PROD_W     = 2 * DATA_WIDTH;
	localparam int RES_W      = 32;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	// Port widths
	localparam int IDX_W      = 3;
	localparam int VAL_W      = 16;
	localparam int MODE_W     = 2;
	localparam int REG_IDX_W  = 2;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 40;

	// Mode codes, also the queue command kinds
	localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

	// Configuration register indexes
	localparam logic [REG_IDX_W-1:0] REG_ROWS_M  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_INNER_K = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_COLS_N  = 2'd2;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(64'sd2147483647);
	localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(64'sd2147483648);

	typedef struct packed {
		logic [MODE_W-1:0]     kind;
		logic [ADDR_W-1:0]     addr;
		logic [DATA_WIDTH-1:0] value;
	} q_entry_t;

	typedef struct packed {
		logic [CNT_W-1:0] m;
		logic [CNT_W-1:0] k;
		logic [CNT_W-1:0] n;
	} dims_t;

	typedef struct packed {
		logic             first;
		logic             elast;
		logic             rlast;
		logic [DIM_W-1:0] i;
		logic [DIM_W-1:0] j;
	} tag_t;

	// Zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [CNT_W-1:0] dim_eff(input logic [CFG_W-1:0] r);
		logic [CNT_W-1:0] d;
		if (r == '0) begin
			d = CNT_W'(1);
		end else if (r > CFG_W'(MAX_DIM)) begin
			d = CNT_W'(MAX_DIM);
		end else begin
			d = CNT_W'(r);
		end
		return d;
	endfunction

endpackage

FILE: rtl/core/matrix_multiply.sv
// Fixed-point matrix multiply C = A x B, Q8.8 operands, Q16.16 saturated results.
// Flow: a load word is written to its store when it reaches the queue head while the
// back end is idle; a run's products pass the store read, multiply and output registers.
// Rates: one load word per cycle while the queue has room; a run forms its products one
// at a time, set by the single shared multiply-accumulate pipeline and one read port per store.
// Reset: size registers return to 8, queue and pipeline empty; stores undefined until written.
module matrix_multiply (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            cfg_we,
	input  logic [mm_pkg::REG_IDX_W-1:0]    cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]        cfg_data,
	// input words
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [mm_pkg::IN_DATA_W-1:0]    s_tdata,  // row[2:0], col[5:3], value[21:6], zero
	input  logic [mm_pkg::MODE_W-1:0]       s_tuser,  // mode[1:0]
	// result words
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [mm_pkg::OUT_DATA_W-1:0]   m_tdata,  // out_row[2:0], out_col[5:3],
	                                                   // product[37:6], zero
	output logic                            m_tlast   // last
);

	logic                     push, pop, q_empty, q_full;
	mm_pkg::q_entry_t         push_entry, head;
	mm_pkg::dims_t            dims;
	logic [mm_pkg::DIM_W-1:0] res_row, res_col;
	logic [mm_pkg::RES_W-1:0] res_product;

	// Accept a word whenever the queue has room; dropped words never enter it.
	assign s_tready = !q_full;

	// Front: hold the sizes, classify each word, drop what falls outside the matrices.
	mm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_row    (s_tdata[2:0]),
		.in_col    (s_tdata[5:3]),
		.in_value  (s_tdata[21:6]),
		.push      (push),
		.entry     (push_entry),
		.dims      (dims)
	);

	// Queue: lets the front keep taking loads while a run drains results.
	mm_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.empty      (q_empty),
		.full       (q_full)
	);

	// Back: write the stores, or sequence a run through the multiply-accumulate pipe.
	mm_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.dims        (dims),
		.head        (head),
		.empty       (q_empty),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_row     (res_row),
		.out_col     (res_col),
		.out_product (res_product),
		.out_last    (m_tlast)
	);

	// Pack the result word, lowest field first, pad to whole bytes.
	assign m_tdata = {2'b00, res_product, res_col, res_row};

endmodule

FILE: rtl/core/mm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		// hold read data while the reader stalls
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/core/mm_front.sv
// Front end: size registers, input word classification and queue entry build.
// Depends on mm_pkg.
module mm_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mm_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]          cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [mm_pkg::MODE_W-1:0]         in_mode,
	input  logic [mm_pkg::IDX_W-1:0]          in_row,
	input  logic [mm_pkg::IDX_W-1:0]          in_col,
	input  logic [mm_pkg::VAL_W-1:0]          in_value,
	output logic                              push,
	output mm_pkg::q_entry_t                  entry,
	output mm_pkg::dims_t                     dims
);

	logic [mm_pkg::CFG_W-1:0] rows_m_q, inner_k_q, cols_n_q;
	logic [mm_pkg::CNT_W-1:0] row_w, col_w;
	logic                     keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_m_q  <= mm_pkg::CFG_RESET;
			inner_k_q <= mm_pkg::CFG_RESET;
			cols_n_q  <= mm_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				mm_pkg::REG_ROWS_M:  rows_m_q  <= cfg_data;
				mm_pkg::REG_INNER_K: inner_k_q <= cfg_data;
				mm_pkg::REG_COLS_N:  cols_n_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dims.m = mm_pkg::dim_eff(rows_m_q);
	assign dims.k = mm_pkg::dim_eff(inner_k_q);
	assign dims.n = mm_pkg::dim_eff(cols_n_q);

	assign row_w = mm_pkg::CNT_W'(in_row);
	assign col_w = mm_pkg::CNT_W'(in_col);

	// drop loads outside the configured size and the unused mode
	always_comb begin
		case (in_mode)
			mm_pkg::MODE_LOAD_A: keep = (row_w < dims.m) && (col_w < dims.k);
			mm_pkg::MODE_LOAD_B: keep = (row_w < dims.k) && (col_w < dims.n);
			mm_pkg::MODE_RUN:    keep = 1'b1;
			default:             keep = 1'b0;
		endcase
	end

	assign push        = in_valid && in_ready && keep;
	assign entry.kind  = in_mode;
	assign entry.addr  = {in_row[mm_pkg::DIM_W-1:0], in_col[mm_pkg::DIM_W-1:0]};
	assign entry.value = mm_pkg::DATA_WIDTH'(in_value);

endmodule

FILE: rtl/core/mm_queue.sv
// Short command queue between the front end and the execution back end.
// Depends on mm_pkg.
module mm_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  mm_pkg::q_entry_t  push_entry,
	input  logic              pop,
	output mm_pkg::q_entry_t  head,
	output logic              empty,
	output logic              full
);

	mm_pkg::q_entry_t          slot_q [mm_pkg::QDEPTH];
	logic [mm_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [mm_pkg::QPTR_W:0]   count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == (mm_pkg::QPTR_W+1)'(mm_pkg::QDEPTH));
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/mm_back.sv
// Back end: operand stores, element sequencer, multiply-accumulate pipeline,
// saturation and output register. Depends on mm_pkg and mm_ram.
module mm_back (
	input  logic                           clk,
	input  logic                           arst_n,
	input  mm_pkg::dims_t                  dims,
	input  mm_pkg::q_entry_t               head,
	input  logic                           empty,
	output logic                           pop,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [mm_pkg::DIM_W-1:0]       out_row,
	output logic [mm_pkg::DIM_W-1:0]       out_col,
	output logic [mm_pkg::RES_W-1:0]       out_product,
	output logic                           out_last
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic                        state_q;
	logic [mm_pkg::DIM_W-1:0]    i_q, j_q, p_q;
	logic                        adv;
	logic                        p_end, j_end, i_end;
	logic                        we_a, we_b;
	logic [mm_pkg::DATA_WIDTH-1:0] a_rd, b_rd;

	logic                        valid_s1, valid_s2;
	mm_pkg::tag_t                tag_s1, tag_s2;
	logic signed [mm_pkg::PROD_W-1:0] prod_s2;
	logic signed [mm_pkg::ACC_W-1:0]  acc_q, acc_sum;
	logic signed [mm_pkg::ACC_W-1:0]  acc_base;
	logic [mm_pkg::RES_W-1:0]    sat;
	logic                        out_valid_q;

	// whole pipeline stalls only while a finished element waits to leave
	assign adv = !out_valid_q || out_ready;

	assign pop  = (state_q == ST_IDLE) && !empty;
	assign we_a = pop && (head.kind == mm_pkg::MODE_LOAD_A);
	assign we_b = pop && (head.kind == mm_pkg::MODE_LOAD_B);

	assign p_end = (mm_pkg::CNT_W'(p_q) + mm_pkg::CNT_W'(1)) == dims.k;
	assign j_end = (mm_pkg::CNT_W'(j_q) + mm_pkg::CNT_W'(1)) == dims.n;
	assign i_end = (mm_pkg::CNT_W'(i_q) + mm_pkg::CNT_W'(1)) == dims.m;

	mm_ram #(.WIDTH(mm_pkg::DATA_WIDTH), .DEPTH(mm_pkg::DEPTH)) u_store_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (head.addr),
		.wdata (head.value),
		.re    (adv),
		.raddr ({i_q, p_q}),
		.rdata (a_rd)
	);

	mm_ram #(.WIDTH(mm_pkg::DATA_WIDTH), .DEPTH(mm_pkg::DEPTH)) u_store_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (head.addr),
		.wdata (head.value),
		.re    (adv),
		.raddr ({p_q, j_q}),
		.rdata (b_rd)
	);

	// sequencer: p innermost, then j, then i
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			p_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pop && head.kind == mm_pkg::MODE_RUN) begin
						state_q <= ST_RUN;
						i_q     <= '0;
						j_q     <= '0;
						p_q     <= '0;
					end
				end
				ST_RUN: begin
					if (adv) begin
						if (!p_end) begin
							p_q <= p_q + 1'b1;
						end else begin
							p_q <= '0;
							if (!j_end) begin
								j_q <= j_q + 1'b1;
							end else begin
								j_q <= '0;
								if (i_end) begin
									state_q <= ST_IDLE;
								end else begin
									i_q <= i_q + 1'b1;
								end
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= (state_q == ST_RUN);
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1.first <= (p_q == '0);
			tag_s1.elast <= p_end;
			tag_s1.rlast <= p_end && j_end && i_end;
			tag_s1.i     <= i_q;
			tag_s1.j     <= j_q;
			tag_s2       <= tag_s1;
			prod_s2      <= $signed(a_rd) * $signed(b_rd);
		end
	end

	assign acc_base = tag_s2.first ? '0 : acc_q;
	assign acc_sum  = acc_base + mm_pkg::ACC_W'(prod_s2);

	always_comb begin
		if (acc_sum > mm_pkg::SAT_MAX) begin
			sat = mm_pkg::RES_W'(mm_pkg::SAT_MAX);
		end else if (acc_sum < mm_pkg::SAT_MIN) begin
			sat = mm_pkg::RES_W'(mm_pkg::SAT_MIN);
		end else begin
			sat = acc_sum[mm_pkg::RES_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			acc_q <= acc_sum;
			if (tag_s2.elast) begin
				out_row     <= tag_s2.i;
				out_col     <= tag_s2.j;
				out_product <= sat;
				out_last    <= tag_s2.rlast;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s2 && tag_s2.elast;
		end
	end

	assign out_valid = out_valid_q;

endmodule
